FILE: hw/rtl/csd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csd_pkg;

  // number of axes that take part in the update
  localparam int AXES  = 3;
  // lanes carried by one item (x, y, z)
  localparam int LANES = 3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_GAIN   = 2'd0,
    CFG_MAX_STEP    = 2'd1,
    CFG_FORCE_LIMIT = 2'd2
  } cfg_idx_t;

  typedef logic signed [31:0] word_t;
  typedef logic [31:0]        mag_t;
  typedef logic [30:0]        lim_t;
  typedef logic [63:0]        prod_t;

  // per-stage load enables, stage 5 is the output register
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

`default_nettype wire

FILE: hw/rtl/capped_steepest_descent_step.sv
// An accepted item passes the lane stages, the merge stage and the output register.
// Throughput: one item per cycle when out_stall is low; each stage advances when empty
// or its successor moves, so bubbles collapse and the output register holds a stalled item.
// Per-axis multipliers (force x gain, force x force) sit in their own stage.
// Reset (synchronous, rst_n low) clears all valid bits, the configuration
// registers and the running force maximum.
`timescale 1ns / 1ps
`default_nettype none

module capped_steepest_descent_step (
  input  wire logic                             clk,
  input  wire logic                             rst_n,

  input  wire logic                             cfg_we,
  input  wire logic [csd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [csd_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [31:0]               in_force_x,
  input  wire logic signed [31:0]               in_force_y,
  input  wire logic signed [31:0]               in_force_z,
  input  wire logic signed [31:0]               in_pos_x,
  input  wire logic signed [31:0]               in_pos_y,
  input  wire logic signed [31:0]               in_pos_z,
  input  wire logic [2:0]                       in_fixed_mask,
  input  wire logic                             in_virtual_flag,
  input  wire logic                             in_last_particle,

  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [31:0]                    out_new_pos_x,
  output logic signed [31:0]                    out_new_pos_y,
  output logic signed [31:0]                    out_new_pos_z,
  output logic                                  out_end_of_step,
  output logic                                  out_converged
);

  csd_pkg::mag_t step_gain_r;
  csd_pkg::lim_t max_step_r;
  csd_pkg::lim_t force_limit_r;

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic last1_r, last2_r, last3_r;

  csd_pkg::pipe_en_t en;

  csd_pkg::word_t force_vec [csd_pkg::LANES];
  csd_pkg::word_t pos_vec   [csd_pkg::LANES];
  csd_pkg::word_t lane_pos  [csd_pkg::LANES];
  csd_pkg::prod_t lane_sq   [csd_pkg::LANES];
  csd_pkg::word_t out_pos   [csd_pkg::LANES];

  assign en.s5 = !out_valid_r || !out_stall;
  assign en.s4 = !v4_r || en.s5;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;

  assign in_stall = !en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_gain_r   <= '0;
      max_step_r    <= '0;
      force_limit_r <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      v4_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          csd_pkg::CFG_STEP_GAIN:   step_gain_r   <= cfg_wdata;
          csd_pkg::CFG_MAX_STEP:    max_step_r    <= cfg_wdata[30:0];
          csd_pkg::CFG_FORCE_LIMIT: force_limit_r <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (en.s1) v1_r        <= in_valid;
      if (en.s2) v2_r        <= v1_r;
      if (en.s3) v3_r        <= v2_r;
      if (en.s4) v4_r        <= v3_r;
      if (en.s5) out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) last1_r <= in_last_particle;
    if (en.s2) last2_r <= last1_r;
    if (en.s3) last3_r <= last2_r;
  end

  assign force_vec[0] = in_force_x;
  assign force_vec[1] = in_force_y;
  assign force_vec[2] = in_force_z;
  assign pos_vec[0]   = in_pos_x;
  assign pos_vec[1]   = in_pos_y;
  assign pos_vec[2]   = in_pos_z;

  for (genvar j = 0; j < csd_pkg::LANES; j++) begin : g_lane
    csd_lane u_lane (
      .clk       (clk),
      .en        (en),
      .force_in  (force_vec[j]),
      .pos_in    (pos_vec[j]),
      .active_in ((j < csd_pkg::AXES) && !in_virtual_flag && !in_fixed_mask[j]),
      .step_gain (step_gain_r),
      .max_step  (max_step_r),
      .new_pos   (lane_pos[j]),
      .force_sq  (lane_sq[j])
    );
  end

  csd_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .v4          (v4_r),
    .pos_in      (lane_pos),
    .sq_in       (lane_sq),
    .last_in     (last3_r),
    .force_limit (force_limit_r),
    .new_pos     (out_pos),
    .end_of_step (out_end_of_step),
    .converged   (out_converged)
  );

  assign out_valid     = out_valid_r;
  assign out_new_pos_x = out_pos[0];
  assign out_new_pos_y = out_pos[1];
  assign out_new_pos_z = out_pos[2];

endmodule

`default_nettype wire

FILE: hw/rtl/csd_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module csd_lane (
  input  wire logic              clk,
  input  wire csd_pkg::pipe_en_t en,
  input  wire csd_pkg::word_t    force_in,
  input  wire csd_pkg::word_t    pos_in,
  input  wire logic              active_in,
  input  wire csd_pkg::mag_t     step_gain,
  input  wire csd_pkg::lim_t     max_step,
  output csd_pkg::word_t         new_pos,
  output csd_pkg::prod_t         force_sq
);

  // stage 1: magnitude and sign
  csd_pkg::mag_t  mag1_r;
  logic           neg1_r;
  csd_pkg::word_t pos1_r;
  logic           act1_r;

  // stage 2: products
  logic [47:0]    step2_r;
  csd_pkg::prod_t sq2_r;
  logic           neg2_r;
  csd_pkg::word_t pos2_r;
  logic           act2_r;

  // stage 3: capped move applied
  csd_pkg::word_t pos3_r;
  csd_pkg::prod_t sq3_r;

  csd_pkg::mag_t   force_u;
  csd_pkg::mag_t   mag_nxt;
  csd_pkg::prod_t  step_prod;
  csd_pkg::prod_t  sq_prod;
  csd_pkg::lim_t   step_cap;
  logic signed [32:0] dp;
  logic signed [32:0] pos_sum;
  csd_pkg::word_t  pos_sat;

  assign force_u = csd_pkg::mag_t'(force_in);
  // -2^31 maps to 2^31, which still fits the unsigned magnitude
  assign mag_nxt = force_in[31] ? (~force_u + 32'd1) : force_u;

  assign step_prod = csd_pkg::prod_t'(mag1_r) * csd_pkg::prod_t'(step_gain);
  assign sq_prod   = csd_pkg::prod_t'(mag1_r) * csd_pkg::prod_t'(mag1_r);

  assign step_cap = (step2_r > {17'd0, max_step}) ? max_step : step2_r[30:0];
  assign dp       = neg2_r ? -$signed({2'b00, step_cap}) : $signed({2'b00, step_cap});
  assign pos_sum  = {pos2_r[31], pos2_r} + dp;

  always_comb begin
    if (pos_sum[32] != pos_sum[31]) begin
      pos_sat = pos_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag1_r <= mag_nxt;
      neg1_r <= force_in[31];
      pos1_r <= pos_in;
      act1_r <= active_in;
    end
    if (en.s2) begin
      step2_r <= step_prod[63:16];
      sq2_r   <= sq_prod;
      neg2_r  <= neg1_r;
      pos2_r  <= pos1_r;
      act2_r  <= act1_r;
    end
    if (en.s3) begin
      pos3_r <= act2_r ? pos_sat : pos2_r;
      sq3_r  <= act2_r ? sq2_r : '0;
    end
  end

  assign new_pos  = pos3_r;
  assign force_sq = sq3_r;

endmodule

`default_nettype wire

FILE: hw/rtl/csd_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module csd_merge (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire csd_pkg::pipe_en_t en,
  input  wire logic              v4,
  input  wire csd_pkg::word_t    pos_in [csd_pkg::LANES],
  input  wire csd_pkg::prod_t    sq_in  [csd_pkg::LANES],
  input  wire logic              last_in,
  input  wire csd_pkg::lim_t     force_limit,
  output csd_pkg::word_t         new_pos [csd_pkg::LANES],
  output logic                   end_of_step,
  output logic                   converged
);

  csd_pkg::prod_t sum4_r;
  csd_pkg::word_t pos4_r [csd_pkg::LANES];
  logic           last4_r;

  csd_pkg::word_t pos5_r [csd_pkg::LANES];
  logic           eos5_r;
  logic           conv5_r;

  csd_pkg::prod_t max_r;
  logic [61:0]    lim_sq_r;

  csd_pkg::prod_t sum_nxt;
  csd_pkg::prod_t max_nxt;

  // each square is at most 2^62, so three of them never wrap 64 bits
  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < csd_pkg::LANES; j++) begin
      sum_nxt = sum_nxt + sq_in[j];
    end
  end

  assign max_nxt = (sum4_r > max_r) ? sum4_r : max_r;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sum4_r  <= sum_nxt;
      pos4_r  <= pos_in;
      last4_r <= last_in;
    end
    if (en.s5) begin
      pos5_r  <= pos4_r;
      eos5_r  <= last4_r;
      conv5_r <= last4_r && (max_nxt < {2'b00, lim_sq_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= '0;
      lim_sq_r <= '0;
    end else begin
      lim_sq_r <= 62'(force_limit) * 62'(force_limit);
      if (en.s5 && v4) begin
        max_r <= last4_r ? '0 : max_nxt;
      end
    end
  end

  assign new_pos     = pos5_r;
  assign end_of_step = eos5_r;
  assign converged   = conv5_r;

endmodule

`default_nettype wire
